>>> rtl/bba_pkg.sv
// Shared types, codes and control structs of the buddy block allocator.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int FM_WORD  = 16;   // free-map bits per RAM word
    localparam int FM_BIT_W = 4;    // bit select within a free-map word

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFREE  = 2'd1;
    localparam logic [1:0] ST_TOOBIG  = 2'd2;
    localparam logic [1:0] ST_NOTALLOC = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [17:0] size_bytes;
        logic [10:0] block_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] result_index;
        logic [13:0] block_bytes;
    } rsp_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_ACLR_RD,
        S_ACLR_WR,
        S_SPLIT,
        S_ASET_RD,
        S_ASET_WR,
        S_AMARK,
        S_FCHK,
        S_QDONE,
        S_MCHK,
        S_MRD,
        S_MTST,
        S_FSET_RD,
        S_FSET_WR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic       clr_step;
        logic       req_load;
        logic       srch_start;
        logic       srch_word;
        logic       srch_order;
        logic       found;
        logic       fm_rd;
        logic       fm_srch;
        logic       fm_wr;
        logic       fm_val;
        logic       fm_bud;
        logic       j_dec;
        logic       unit_add;
        logic       merge;
        logic       ao_rd;
        logic       ao_mark;
        logic       ao_zero;
        logic       fr_load;
        logic       res_ok;
        logic       res_err;
        logic [1:0] res_code;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic [1:0] req_type;
        logic       too_big;
        logic       heap_empty;
        logic       idx_bad;
        logic       word_nz;
        logic       woff_zero;
        logic       j_top;
        logic       j_gt_k;
        logic       ao_empty;
        logic       bit_free;
        logic       out_free;
    } sts_t;

endpackage

>>> rtl/bba_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [W-1:0]  wdata,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/bba_ctrl.sv
// Sequencer for search, split, merge and clearing of the allocator.
`timescale 1ns / 1ps

module bba_ctrl
    import bba_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_we,
    input  logic   req_valid,
    output logic   req_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (sts.clear_done) state_next = S_IDLE;
            S_IDLE:     if (req_valid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                unique case (sts.req_type) inside
                    REQ_ALLOC:
                        state_next = (sts.too_big || sts.heap_empty) ? S_RESULT : S_SRCH_RD;
                    REQ_FREE, REQ_QUERY:
                        state_next = sts.idx_bad ? S_RESULT : S_FCHK;
                    default:
                        state_next = S_RESULT;
                endcase
            end
            S_SRCH_RD:  state_next = S_SRCH_CHK;
            S_SRCH_CHK:
            begin
                if (sts.word_nz)
                    state_next = S_ACLR_RD;
                else if (sts.woff_zero && sts.j_top)
                    state_next = S_RESULT;
                else
                    state_next = S_SRCH_RD;
            end
            S_ACLR_RD:  state_next = S_ACLR_WR;
            S_ACLR_WR:  state_next = S_SPLIT;
            S_SPLIT:    state_next = sts.j_gt_k ? S_ASET_RD : S_AMARK;
            S_ASET_RD:  state_next = S_ASET_WR;
            S_ASET_WR:  state_next = S_SPLIT;
            S_AMARK:    state_next = S_RESULT;
            S_FCHK:
            begin
                if (sts.ao_empty)
                    state_next = S_RESULT;
                else if (sts.req_type == REQ_QUERY)
                    state_next = S_QDONE;
                else
                    state_next = S_MCHK;
            end
            S_QDONE:    state_next = S_RESULT;
            S_MCHK:     state_next = sts.j_top ? S_FSET_RD : S_MRD;
            S_MRD:      state_next = S_MTST;
            S_MTST:     state_next = sts.bit_free ? S_MCHK : S_FSET_RD;
            S_FSET_RD:  state_next = S_FSET_WR;
            S_FSET_WR:  state_next = S_RESULT;
            S_RESULT:   if (sts.out_free) state_next = S_IDLE;
            default:    state_next = S_CLEAR;
        endcase
        if (cfg_we)
        begin
            state_next = S_CLEAR;
        end
    end

    always_comb
    begin
        cmd = '0;
        req_ready = 1'b0;
        unique case (state_reg) inside
            S_CLEAR:    cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.req_load = req_valid;
            end
            S_DISPATCH:
            begin
                unique case (sts.req_type) inside
                    REQ_ALLOC:
                    begin
                        if (sts.too_big)
                        begin
                            cmd.res_err = 1'b1;
                            cmd.res_code = ST_TOOBIG;
                        end
                        else if (sts.heap_empty)
                        begin
                            cmd.res_err = 1'b1;
                            cmd.res_code = ST_NOFREE;
                        end
                        else
                        begin
                            cmd.srch_start = 1'b1;
                        end
                    end
                    REQ_FREE, REQ_QUERY:
                    begin
                        if (sts.idx_bad)
                        begin
                            cmd.res_err = 1'b1;
                            cmd.res_code = ST_NOTALLOC;
                        end
                        else
                        begin
                            cmd.ao_rd = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.res_err = 1'b1;
                        cmd.res_code = ST_NOTALLOC;
                    end
                endcase
            end
            S_SRCH_RD:
            begin
                cmd.fm_rd = 1'b1;
                cmd.fm_srch = 1'b1;
            end
            S_SRCH_CHK:
            begin
                if (sts.word_nz)
                    cmd.found = 1'b1;
                else if (sts.woff_zero && sts.j_top)
                begin
                    cmd.res_err = 1'b1;
                    cmd.res_code = ST_NOFREE;
                end
                else if (sts.woff_zero)
                    cmd.srch_order = 1'b1;
                else
                    cmd.srch_word = 1'b1;
            end
            S_ACLR_RD, S_ASET_RD, S_FSET_RD: cmd.fm_rd = 1'b1;
            S_ACLR_WR:  cmd.fm_wr = 1'b1;
            S_SPLIT:    cmd.j_dec = sts.j_gt_k;
            S_ASET_WR:
            begin
                cmd.fm_wr = 1'b1;
                cmd.fm_val = 1'b1;
                cmd.unit_add = 1'b1;
            end
            S_AMARK:
            begin
                cmd.ao_mark = 1'b1;
                cmd.res_ok = 1'b1;
            end
            S_FCHK:
            begin
                if (sts.ao_empty)
                begin
                    cmd.res_err = 1'b1;
                    cmd.res_code = ST_NOTALLOC;
                end
                else
                begin
                    cmd.fr_load = 1'b1;
                    cmd.ao_zero = (sts.req_type == REQ_FREE);
                end
            end
            S_QDONE:    cmd.res_ok = 1'b1;
            S_MCHK:     ;
            S_MRD:
            begin
                cmd.fm_rd = 1'b1;
                cmd.fm_bud = 1'b1;
            end
            S_MTST:
            begin
                if (sts.bit_free)
                begin
                    cmd.fm_wr = 1'b1;
                    cmd.fm_bud = 1'b1;
                    cmd.merge = 1'b1;
                end
            end
            S_FSET_WR:
            begin
                cmd.fm_wr = 1'b1;
                cmd.fm_val = 1'b1;
                cmd.res_ok = 1'b1;
            end
            S_RESULT:   cmd.out_load = sts.out_free;
            default:    ;
        endcase
    end

endmodule

>>> rtl/bba_datapath.sv
// Free map, allocation table, address generation and result registers.
`timescale 1ns / 1ps

module bba_datapath
    import bba_pkg::*;
#(
    parameter int MIN_BLOCK_BYTES = 64,
    parameter int NUM_ORDERS      = 8,
    parameter int TOP_BLOCKS      = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  req_t       req,
    input  logic       rsp_ready,
    input  cmd_t       cmd,
    output sts_t       sts,
    output logic       rsp_valid,
    output rsp_t       rsp
);

    localparam int T      = NUM_ORDERS - 1;
    localparam int HEAP   = TOP_BLOCKS << T;
    localparam int UW     = $clog2(HEAP);
    localparam int OW     = $clog2(NUM_ORDERS);
    localparam int AOW    = $clog2(NUM_ORDERS + 1);
    localparam int TBW    = $clog2(TOP_BLOCKS + 1);

    function automatic int nwords(int o);
        return ((TOP_BLOCKS << (T - o)) + FM_WORD - 1) / FM_WORD;
    endfunction

    function automatic int base_of(int o);
        int s;
        s = 0;
        for (int i = 0; i < o; i++)
            s += nwords(i);
        return s;
    endfunction

    localparam int FW     = base_of(NUM_ORDERS);
    localparam int FAW    = (FW > 1) ? $clog2(FW) : 1;
    localparam int NWMAX  = nwords(0);
    localparam int WOW    = (NWMAX > 1) ? $clog2(NWMAX) : 1;
    localparam int CLR_N  = (HEAP > FW) ? HEAP : FW;
    localparam int CW     = $clog2(CLR_N);

    logic [FAW-1:0] base_w [NUM_ORDERS];
    for (genvar o = 0; o < NUM_ORDERS; o++)
    begin : g_base
        assign base_w[o] = FAW'(base_of(o));
    end

    logic [4:0]     tbc_reg;
    logic [CW-1:0]  clr_cnt_reg;
    logic           out_valid_reg;
    rsp_t           out_reg;

    req_t           req_reg;
    logic [OW-1:0]  ord_k_reg, ord_j_reg;
    logic           too_big_reg;
    logic [UW-1:0]  unit_reg;
    logic [WOW-1:0] woff_reg;
    rsp_t           res_reg;

    logic [TBW-1:0] tbc_eff;
    logic [UW:0]    act_units;

    logic [FAW-1:0]      fm_addr;
    logic                fm_we;
    logic [FM_WORD-1:0]  fm_wdata, fm_rdata;
    logic [UW-1:0]       ao_addr;
    logic                ao_we;
    logic [AOW-1:0]      ao_wdata, ao_rdata;

    assign tbc_eff = (32'(tbc_reg) > 32'(TOP_BLOCKS)) ? TBW'(TOP_BLOCKS) : TBW'(tbc_reg);
    assign act_units = (UW + 1)'(tbc_eff) << T;

    // size to order
    logic [OW-1:0] k_calc;
    logic          big_calc;
    always_comb
    begin
        int c;
        c = 0;
        for (int o = 0; o < T; o++)
        begin
            if ({14'd0, req.size_bytes} > (32'(MIN_BLOCK_BYTES) << o))
                c++;
        end
        k_calc = OW'(c);
        big_calc = {14'd0, req.size_bytes} > (32'(MIN_BLOCK_BYTES) << T);
    end

    // first word of a scan: the one holding the highest active block of the order
    logic [UW:0]    sh_k, sh_n, m1_k, m1_n;
    logic [OW-1:0]  j_inc;
    logic [WOW-1:0] start_k, start_n;
    assign j_inc = ord_j_reg + OW'(1);
    assign sh_k = act_units >> ord_k_reg;
    assign sh_n = act_units >> j_inc;
    assign m1_k = sh_k - (UW + 1)'(1);
    assign m1_n = sh_n - (UW + 1)'(1);
    assign start_k = WOW'(m1_k >> FM_BIT_W);
    assign start_n = WOW'(m1_n >> FM_BIT_W);

    // bit addresses of the working block and of its buddy
    logic [UW-1:0]       bud_unit, n_self, n_bud;
    logic [FAW-1:0]      addr_self, addr_bud;
    logic [FM_BIT_W-1:0] pos_self, pos_bud, pos_wr;
    assign bud_unit  = unit_reg ^ (UW'(1) << ord_j_reg);
    assign n_self    = unit_reg >> ord_j_reg;
    assign n_bud     = bud_unit >> ord_j_reg;
    assign addr_self = base_w[ord_j_reg] + FAW'(n_self >> FM_BIT_W);
    assign addr_bud  = base_w[ord_j_reg] + FAW'(n_bud >> FM_BIT_W);
    assign pos_self  = FM_BIT_W'(n_self);
    assign pos_bud   = FM_BIT_W'(n_bud);
    assign pos_wr    = cmd.fm_bud ? pos_bud : pos_self;

    logic [FM_BIT_W-1:0] hibit;
    always_comb
    begin
        hibit = '0;
        for (int i = 0; i < FM_WORD; i++)
        begin
            if (fm_rdata[i])
                hibit = FM_BIT_W'(i);
        end
    end

    // top-order word contents during the clearing pass
    logic                clr_fm, clr_ao;
    logic [FM_WORD-1:0]  init_word;
    logic [31:0]         top_off;
    assign clr_fm = cmd.clr_step && (32'(clr_cnt_reg) < 32'(FW));
    assign clr_ao = cmd.clr_step && (32'(clr_cnt_reg) < 32'(HEAP));
    assign top_off = 32'(clr_cnt_reg) - 32'(base_w[T]);
    always_comb
    begin
        init_word = '0;
        if (32'(clr_cnt_reg) >= 32'(base_w[T]))
        begin
            for (int b = 0; b < FM_WORD; b++)
                init_word[b] = (top_off * 32'(FM_WORD) + 32'(b)) < 32'(tbc_eff);
        end
    end

    always_comb
    begin
        if (cmd.clr_step)
            fm_addr = FAW'(clr_cnt_reg);
        else if (cmd.fm_srch)
            fm_addr = base_w[ord_j_reg] + FAW'(woff_reg);
        else if (cmd.fm_bud)
            fm_addr = addr_bud;
        else
            fm_addr = addr_self;
        fm_we = clr_fm || cmd.fm_wr;
        fm_wdata = fm_rdata;
        fm_wdata[pos_wr] = cmd.fm_val;
        if (cmd.clr_step)
            fm_wdata = init_word;
    end

    always_comb
    begin
        if (cmd.clr_step)
            ao_addr = UW'(clr_cnt_reg);
        else if (cmd.ao_mark)
            ao_addr = unit_reg;
        else
            ao_addr = UW'(req_reg.block_index);
        ao_we = clr_ao || cmd.ao_mark || cmd.ao_zero;
        ao_wdata = cmd.ao_mark ? AOW'(ord_k_reg) + AOW'(1) : '0;
    end

    bba_ram #(.W(FM_WORD), .D(FW)) u_free_map (
        .clk   (clk),
        .we    (fm_we),
        .addr  (fm_addr),
        .wdata (fm_wdata),
        .rdata (fm_rdata)
    );

    bba_ram #(.W(AOW), .D(HEAP)) u_alloc_order (
        .clk   (clk),
        .we    (ao_we),
        .addr  (ao_addr),
        .wdata (ao_wdata),
        .rdata (ao_rdata)
    );

    logic [31:0] bytes32;
    assign bytes32 = 32'(MIN_BLOCK_BYTES) << ord_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbc_reg       <= 5'd16;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tbc_reg     <= cfg_wdata;
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_reg     <= req;
            ord_k_reg   <= k_calc;
            too_big_reg <= big_calc;
        end
        if (cmd.srch_start)
        begin
            ord_j_reg <= ord_k_reg;
            woff_reg  <= start_k;
        end
        if (cmd.srch_word)
            woff_reg <= woff_reg - WOW'(1);
        if (cmd.srch_order)
        begin
            ord_j_reg <= j_inc;
            woff_reg  <= start_n;
        end
        if (cmd.found)
            unit_reg <= ((UW'(woff_reg) << FM_BIT_W) | UW'(hibit)) << ord_j_reg;
        if (cmd.j_dec)
            ord_j_reg <= ord_j_reg - OW'(1);
        if (cmd.unit_add)
            unit_reg <= unit_reg + (UW'(1) << ord_j_reg);
        if (cmd.merge)
        begin
            unit_reg  <= unit_reg & ~(UW'(1) << ord_j_reg);
            ord_j_reg <= j_inc;
        end
        if (cmd.fr_load)
        begin
            ord_k_reg <= OW'(ao_rdata - AOW'(1));
            ord_j_reg <= OW'(ao_rdata - AOW'(1));
            unit_reg  <= UW'(req_reg.block_index);
        end
        if (cmd.res_ok)
        begin
            res_reg.status       <= ST_OK;
            res_reg.result_index <= (req_reg.req_type == REQ_ALLOC) ?
                                    11'(unit_reg) : req_reg.block_index;
            res_reg.block_bytes  <= bytes32[13:0];
        end
        if (cmd.res_err)
        begin
            res_reg.status       <= cmd.res_code;
            res_reg.result_index <= '0;
            res_reg.block_bytes  <= '0;
        end
        if (cmd.out_load)
            out_reg <= res_reg;
    end

    always_comb
    begin
        sts.clear_done = (clr_cnt_reg == CW'(CLR_N - 1));
        sts.req_type   = req_reg.req_type;
        sts.too_big    = too_big_reg;
        sts.heap_empty = (tbc_eff == '0);
        sts.idx_bad    = {21'd0, req_reg.block_index} >= 32'(HEAP);
        sts.word_nz    = (fm_rdata != '0);
        sts.woff_zero  = (woff_reg == '0);
        sts.j_top      = (ord_j_reg == OW'(T));
        sts.j_gt_k     = (ord_j_reg > ord_k_reg);
        sts.ao_empty   = (ao_rdata == '0);
        sts.bit_free   = fm_rdata[pos_bud];
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

endmodule

>>> rtl/buddy_block_allocator.sv
// Buddy block allocator top level: sequencer plus datapath.
// An allocation scans free-map words and then splits the found block; a free merges it with free buddies;
// a query reads only the allocation table; every result is loaded into the output register.
// One request at a time, set by the single free-map RAM port. After reset and after every
// top_block_count write a clearing pass over the free map and the allocation table runs
// with req_ready low. Reset gives top_block_count 16.
`timescale 1ns / 1ps

module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int MIN_BLOCK_BYTES = 64,
    parameter int NUM_ORDERS      = 8,
    parameter int TOP_BLOCKS      = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp
);

    cmd_t cmd;
    sts_t sts;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bba_datapath #(
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .NUM_ORDERS      (NUM_ORDERS),
        .TOP_BLOCKS      (TOP_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the buddy block allocator: random and directed requests.
`timescale 1ns / 1ps

module testbench;
    import bba_pkg::*;

    localparam int MINB   = 64;
    localparam int TOPO   = 7;
    localparam int TOPB   = 16;
    localparam int UNITS  = TOPB << TOPO;
    localparam int FDEPTH = 2 * UNITS - TOPB;
    localparam int STALL_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;

    buddy_block_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // allocator state mirror
    bit          free_bits [FDEPTH];
    logic [3:0]  blk_order [UNITS];
    int unsigned heap_tops;
    int          live_blocks [$];

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    bit   req_taken;
    bit   calm;
    bit   failed;
    int   idle_cycles;

    function automatic int unsigned map_pos(int unsigned o, int unsigned u);
        int unsigned pos;
        pos = 2 * UNITS - ((2 * UNITS) >> o) + (u >> o);
        return (pos < FDEPTH) ? pos : 0;
    endfunction

    function automatic int unsigned heap_units();
        return ((heap_tops > TOPB) ? TOPB : heap_tops) << TOPO;
    endfunction

    function automatic void reinit_heap(int unsigned tops);
        heap_tops = tops;
        foreach (free_bits[i]) free_bits[i] = 1'b0;
        foreach (blk_order[i]) blk_order[i] = 4'd0;
        live_blocks.delete();
        for (int unsigned u = 0; u < heap_units(); u += (1 << TOPO))
            free_bits[map_pos(TOPO, u)] = 1'b1;
    endfunction

    function automatic int find_free(int unsigned o);
        int unsigned n;
        n = heap_units() >> o;
        while (n > 0)
        begin
            n--;
            if (free_bits[map_pos(o, n << o)])
                return n << o;
        end
        return -1;
    endfunction

    function automatic rsp_t predict_response(req_t r);
        rsp_t        e;
        int unsigned k, j, a, b, blk;
        int          found;
        e = '0;
        e.status = ST_NOTALLOC;
        if (r.req_type == REQ_ALLOC)
        begin
            k = 0;
            blk = MINB;
            while (r.size_bytes > blk && k < TOPO)
            begin
                blk <<= 1;
                k++;
            end
            if (r.size_bytes > blk)
                e.status = ST_TOOBIG;
            else
            begin
                found = -1;
                for (j = k; j <= TOPO; j++)
                begin
                    found = find_free(j);
                    if (found >= 0)
                        break;
                end
                if (found < 0)
                    e.status = ST_NOFREE;
                else
                begin
                    a = found;
                    free_bits[map_pos(j, a)] = 1'b0;
                    // keep lower halves free, hand out the last upper half
                    while (j > k)
                    begin
                        j--;
                        free_bits[map_pos(j, a)] = 1'b1;
                        a += (1 << j);
                    end
                    blk_order[a] = k + 1;
                    live_blocks.push_back(a);
                    e.status = ST_OK;
                    e.result_index = a;
                    e.block_bytes = blk;
                end
            end
        end
        else if ((r.req_type == REQ_FREE || r.req_type == REQ_QUERY)
                 && blk_order[r.block_index] != 0)
        begin
            k = blk_order[r.block_index] - 1;
            e.status = ST_OK;
            e.result_index = r.block_index;
            e.block_bytes = MINB << k;
            if (r.req_type == REQ_FREE)
            begin
                a = r.block_index;
                blk_order[a] = 4'd0;
                foreach (live_blocks[i])
                    if (live_blocks[i] == a)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
                while (k < TOPO)
                begin
                    b = a ^ (1 << k);
                    if (!free_bits[map_pos(k, b)])
                        break;
                    free_bits[map_pos(k, b)] = 1'b0;
                    a &= ~(1 << k);
                    k++;
                end
                free_bits[map_pos(k, a)] = 1'b1;
            end
        end
        return e;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= calm || ($urandom_range(99) >= 14);
            if (!req_valid || req_taken)
            begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 14))
                begin
                    req_valid <= 1'b1;
                    req <= pending_reqs.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor, checker, watchdog
    always @(posedge clk)
    begin
        rsp_t got, want;
        req_taken = 1'b0;
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_we)
                reinit_heap(cfg_wdata);
            if (req_valid && req_ready)
            begin
                req_taken = 1'b1;
                idle_cycles = 0;
                expected_rsps.push_back(predict_response(req));
            end
            if (rsp_valid && rsp_ready)
            begin
                idle_cycles = 0;
                got = rsp;
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected beat, actual %h", $time, got);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        failed = 1'b1;
                    end
                    if (got.result_index !== want.result_index)
                    begin
                        $display("%0t: result_index expected %0d actual %0d",
                                 $time, want.result_index, got.result_index);
                        failed = 1'b1;
                    end
                    if (got.block_bytes !== want.block_bytes)
                    begin
                        $display("%0t: block_bytes expected %0d actual %0d",
                                 $time, want.block_bytes, got.block_bytes);
                        failed = 1'b1;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic push_req(logic [1:0] t, int unsigned sz, int unsigned idx);
        req_t r;
        r.req_type = t;
        r.size_bytes = sz;
        r.block_index = idx;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
    endtask

    task automatic write_top_blocks(logic [4:0] v);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_req();
        int unsigned k, blk, pick, sz;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            k = ($urandom_range(1)) ? $urandom_range(0, 2) : $urandom_range(0, 7);
            blk = MINB << k;
            case ($urandom_range(3))
                0: sz = blk;
                1: sz = (k == 0) ? 0 : blk / 2 + 1;
                2: sz = $urandom_range((k == 0) ? 0 : blk / 2 + 1, blk);
                default: sz = $urandom_range(0, blk);
            endcase
            if ($urandom_range(19) == 0)
                sz = $urandom_range(MINB << TOPO + 1, 262143);
            push_req(REQ_ALLOC, sz, $urandom_range(2047));
        end
        else if (pick < 90 && live_blocks.size() != 0)
            push_req((pick < 80) ? REQ_FREE : REQ_QUERY, $urandom_range(262143),
                     live_blocks[$urandom_range(live_blocks.size() - 1)]);
        else
            push_req($urandom_range(3), $urandom_range(262143), $urandom_range(2047));
    endtask

    task automatic random_phase(int n, bit pause_midway);
        for (int i = 0; i < n; i++)
        begin
            while (pending_reqs.size() > 1)
                @(negedge clk);
            if (pause_midway && i == n / 2)
                wait_drained();
            random_req();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_valid = 1'b0;
        rsp_ready = 1'b0;
        req = '0;
        calm = 1'b0;
        failed = 1'b0;
        idle_cycles = 0;
        req_taken = 1'b0;
        reinit_heap(16);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: size boundaries, too big, bad codes
        push_req(REQ_ALLOC, 0, 0);
        push_req(REQ_ALLOC, 64, 0);
        push_req(REQ_ALLOC, 65, 2047);
        push_req(REQ_ALLOC, 8192, 0);
        push_req(REQ_ALLOC, 8193, 0);
        push_req(REQ_ALLOC, 262143, 0);
        push_req(REQ_ALLOC, 4096, 0);
        push_req(REQ_QUERY, 0, 0);
        push_req(REQ_FREE, 0, 1);
        push_req(2'd3, 262143, 2047);
        wait_drained();
        push_req(REQ_QUERY, 0, live_blocks[0]);
        push_req(REQ_QUERY, 0, live_blocks[1]);
        foreach (live_blocks[i])
            push_req(REQ_FREE, 0, live_blocks[i]);
        push_req(REQ_FREE, 0, 2047);
        push_req(REQ_QUERY, 0, 2047);
        wait_drained();

        write_top_blocks(5'd16);
        random_phase(240, 1'b1);
        write_top_blocks(5'd1);
        random_phase(80, 1'b0);
        write_top_blocks(5'd0);
        push_req(REQ_ALLOC, 0, 0);
        random_phase(20, 1'b0);
        write_top_blocks(5'd31);
        calm = 1'b1;
        random_phase(150, 1'b0);
        wait_drained();
        calm = 1'b0;
        write_top_blocks(5'd3);
        random_phase(80, 1'b0);
        write_top_blocks(5'd16);
        random_phase(70, 1'b0);

        wait_drained();
        repeat (100) @(posedge clk);
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
